### design/tkst_pkg.sv
package tkst_pkg;

    localparam int MaxKept    = 16;
    localparam int DocBits    = 32;
    localparam int ScoreBits  = 32;
    localparam int SlotBits   = $clog2(MaxKept);
    localparam int CountBits  = $clog2(MaxKept + 1);
    localparam int KeepBits   = 5;
    localparam int KeepReset  = 5;
    localparam int CfgAddrBits = 3;
    localparam int CfgDataBits = 32;
    localparam int RegKeepCount = 0;

    typedef logic [DocBits-1:0]          doc_t;
    typedef logic signed [ScoreBits-1:0] score_t;
    typedef logic [SlotBits-1:0]         slot_t;
    typedef logic [CountBits-1:0]        count_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FSCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic   rd_en;
        slot_t  rd_addr;
        logic   wr_en;
        slot_t  wr_addr;
        doc_t   wr_doc;
        score_t wr_score;
        logic   set_used;
        logic   clear_all;
    } store_req_t;

    typedef struct packed {
        doc_t   doc;
        score_t score;
    } store_rd_t;

    function automatic score_t sat_add(score_t a, score_t b);
        logic signed [ScoreBits:0] s;
        score_t r;
        s = {a[ScoreBits-1], a} + {b[ScoreBits-1], b};
        if (s[ScoreBits] != s[ScoreBits-1])
        begin
            r = s[ScoreBits] ? {1'b1, {(ScoreBits-1){1'b0}}} : {1'b0, {(ScoreBits-1){1'b1}}};
        end
        else
        begin
            r = s[ScoreBits-1:0];
        end
        return r;
    endfunction

endpackage

### design/tkst_if.sv
interface tkst_item_if;
    logic                  valid;
    logic                  ready;
    tkst_pkg::doc_t        doc_id;
    tkst_pkg::score_t      score;
    logic                  query_end;

    modport source (output valid, output doc_id, output score, output query_end, input ready);
    modport sink (input valid, input doc_id, input score, input query_end, output ready);
endinterface

interface tkst_result_if;
    logic                  valid;
    logic                  ready;
    tkst_pkg::doc_t        out_doc_id;
    tkst_pkg::score_t      out_score;
    logic                  last;

    modport source (output valid, output out_doc_id, output out_score, output last, input ready);
    modport sink (input valid, input out_doc_id, input out_score, input last, output ready);
endinterface

### design/tkst_cfg.sv
module tkst_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tkst_pkg::CfgAddrBits-1:0]    paddr,
    input  logic [tkst_pkg::CfgDataBits-1:0]    pwdata,
    output logic [tkst_pkg::CfgDataBits-1:0]    prdata,
    output tkst_pkg::count_t                    eff_k
);

    logic [tkst_pkg::KeepBits-1:0] keep_count_reg;
    logic [tkst_pkg::KeepBits-1:0] keep_count_next;
    logic                          sel_keep;

    assign sel_keep = (paddr[tkst_pkg::CfgAddrBits-1:2]
                       == (tkst_pkg::CfgAddrBits-2)'(tkst_pkg::RegKeepCount));

    always_comb
    begin
        keep_count_next = keep_count_reg;
        if (psel && penable && pwrite && sel_keep)
        begin
            keep_count_next = pwdata[tkst_pkg::KeepBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tkst_pkg::KeepBits'(tkst_pkg::KeepReset);
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_keep)
        begin
            prdata = tkst_pkg::CfgDataBits'(keep_count_reg);
        end
    end

    // zero acts as one, oversize clamps to the store depth
    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            eff_k = tkst_pkg::CountBits'(1);
        end
        else if (32'(keep_count_reg) > tkst_pkg::MaxKept)
        begin
            eff_k = tkst_pkg::CountBits'(tkst_pkg::MaxKept);
        end
        else
        begin
            eff_k = tkst_pkg::CountBits'(keep_count_reg);
        end
    end

endmodule

### design/tkst_store.sv
module tkst_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tkst_pkg::store_req_t             req,
    output tkst_pkg::store_rd_t              rd,
    output logic [tkst_pkg::MaxKept-1:0]     used
);

    tkst_pkg::store_rd_t              mem [tkst_pkg::MaxKept];
    tkst_pkg::store_rd_t              rd_reg;
    logic [tkst_pkg::MaxKept-1:0]     used_reg;
    logic [tkst_pkg::MaxKept-1:0]     used_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= '{doc: req.wr_doc, score: req.wr_score};
        end
        if (req.rd_en)
        begin
            rd_reg <= mem[req.rd_addr];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (req.clear_all)
        begin
            used_next = '0;
        end
        else if (req.wr_en && req.set_used)
        begin
            used_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign rd   = rd_reg;
    assign used = used_reg;

endmodule

### design/tkst_engine.sv
module tkst_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tkst_pkg::count_t                 eff_k,
    tkst_item_if.sink                        item,
    tkst_result_if.source                    result,
    output tkst_pkg::store_req_t             req,
    input  tkst_pkg::store_rd_t              rd,
    input  logic [tkst_pkg::MaxKept-1:0]     used
);

    tkst_pkg::state_t  state_reg, state_next;

    tkst_pkg::count_t  iss_reg, iss_next;
    logic              vld_reg, vld_next;
    tkst_pkg::slot_t   cmp_reg, cmp_next;

    tkst_pkg::doc_t    id_reg, id_next;
    tkst_pkg::score_t  sc_reg, sc_next;
    logic              qend_reg, qend_next;

    logic              hit_reg, hit_next;
    tkst_pkg::slot_t   hit_slot_reg, hit_slot_next;
    tkst_pkg::score_t  hit_score_reg, hit_score_next;
    logic              free_ok_reg, free_ok_next;
    tkst_pkg::slot_t   free_slot_reg, free_slot_next;
    logic              sel_ok_reg, sel_ok_next;
    tkst_pkg::slot_t   sel_slot_reg, sel_slot_next;
    tkst_pkg::score_t  sel_score_reg, sel_score_next;
    tkst_pkg::doc_t    sel_doc_reg, sel_doc_next;
    tkst_pkg::count_t  cnt_reg, cnt_next;
    logic [tkst_pkg::MaxKept-1:0] done_reg, done_next;

    logic              ovld_reg, ovld_next;
    tkst_pkg::doc_t    odoc_reg, odoc_next;
    tkst_pkg::score_t  oscore_reg, oscore_next;
    logic              olast_reg, olast_next;

    logic              issue_ok;
    logic              scan_end;

    assign issue_ok = (32'(iss_reg) < tkst_pkg::MaxKept);
    assign scan_end = vld_reg && (cmp_reg == tkst_pkg::SlotBits'(tkst_pkg::MaxKept - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkst_pkg::ST_IDLE;
            vld_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            ovld_reg  <= ovld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_reg       <= iss_next;
        cmp_reg       <= cmp_next;
        id_reg        <= id_next;
        sc_reg        <= sc_next;
        qend_reg      <= qend_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        hit_score_reg <= hit_score_next;
        free_ok_reg   <= free_ok_next;
        free_slot_reg <= free_slot_next;
        sel_ok_reg    <= sel_ok_next;
        sel_slot_reg  <= sel_slot_next;
        sel_score_reg <= sel_score_next;
        sel_doc_reg   <= sel_doc_next;
        cnt_reg       <= cnt_next;
        odoc_reg      <= odoc_next;
        oscore_reg    <= oscore_next;
        olast_reg     <= olast_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        vld_next       = 1'b0;
        cmp_next       = cmp_reg;
        id_next        = id_reg;
        sc_next        = sc_reg;
        qend_next      = qend_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_score_next = hit_score_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        sel_ok_next    = sel_ok_reg;
        sel_slot_next  = sel_slot_reg;
        sel_score_next = sel_score_reg;
        sel_doc_next   = sel_doc_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        ovld_next      = ovld_reg;
        odoc_next      = odoc_reg;
        oscore_next    = oscore_reg;
        olast_next     = olast_reg;
        req            = '0;
        item.ready     = 1'b0;

        if (ovld_reg && result.ready)
        begin
            ovld_next = 1'b0;
        end

        // one read per cycle while a scan is running
        if ((state_reg == tkst_pkg::ST_SCAN || state_reg == tkst_pkg::ST_FSCAN) && issue_ok)
        begin
            req.rd_en   = 1'b1;
            req.rd_addr = iss_reg[tkst_pkg::SlotBits-1:0];
            iss_next    = iss_reg + 1'b1;
            vld_next    = 1'b1;
            cmp_next    = iss_reg[tkst_pkg::SlotBits-1:0];
        end

        case (state_reg)
            tkst_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    id_next      = item.doc_id;
                    sc_next      = item.score;
                    qend_next    = item.query_end;
                    iss_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    sel_ok_next  = 1'b0;
                    cnt_next     = '0;
                    state_next   = tkst_pkg::ST_SCAN;
                end
            end

            tkst_pkg::ST_SCAN:
            begin
                if (vld_reg)
                begin
                    if (used[cmp_reg])
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (!hit_reg && rd.doc == id_reg)
                        begin
                            hit_next       = 1'b1;
                            hit_slot_next  = cmp_reg;
                            hit_score_next = rd.score;
                        end
                        if (!sel_ok_reg || rd.score < sel_score_reg)
                        begin
                            sel_ok_next    = 1'b1;
                            sel_slot_next  = cmp_reg;
                            sel_score_next = rd.score;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next   = 1'b1;
                        free_slot_next = cmp_reg;
                    end
                end
                if (scan_end)
                begin
                    state_next = tkst_pkg::ST_UPDATE;
                end
            end

            tkst_pkg::ST_UPDATE:
            begin
                req.wr_doc = id_reg;
                if (hit_reg)
                begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = hit_slot_reg;
                    req.wr_score = tkst_pkg::sat_add(hit_score_reg, sc_reg);
                end
                else if (cnt_reg < eff_k && free_ok_reg)
                begin
                    req.wr_en    = 1'b1;
                    req.set_used = 1'b1;
                    req.wr_addr  = free_slot_reg;
                    req.wr_score = sc_reg;
                end
                else if (sel_ok_reg && sc_reg > sel_score_reg)
                begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = sel_slot_reg;
                    req.wr_score = sc_reg;
                end
                if (qend_reg)
                begin
                    done_next   = '0;
                    iss_next    = '0;
                    sel_ok_next = 1'b0;
                    cnt_next    = '0;
                    state_next  = tkst_pkg::ST_FSCAN;
                end
                else
                begin
                    state_next = tkst_pkg::ST_IDLE;
                end
            end

            tkst_pkg::ST_FSCAN:
            begin
                if (vld_reg && used[cmp_reg] && !done_reg[cmp_reg])
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!sel_ok_reg || rd.score > sel_score_reg)
                    begin
                        sel_ok_next    = 1'b1;
                        sel_slot_next  = cmp_reg;
                        sel_score_next = rd.score;
                        sel_doc_next   = rd.doc;
                    end
                end
                if (scan_end)
                begin
                    state_next = tkst_pkg::ST_EMIT;
                end
            end

            tkst_pkg::ST_EMIT:
            begin
                if (!sel_ok_reg)
                begin
                    req.clear_all = 1'b1;
                    state_next    = tkst_pkg::ST_IDLE;
                end
                else if (!ovld_reg || result.ready)
                begin
                    ovld_next              = 1'b1;
                    odoc_next              = sel_doc_reg;
                    oscore_next            = sel_score_reg;
                    olast_next             = (cnt_reg == tkst_pkg::CountBits'(1));
                    done_next[sel_slot_reg] = 1'b1;
                    if (cnt_reg == tkst_pkg::CountBits'(1))
                    begin
                        req.clear_all = 1'b1;
                        state_next    = tkst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        iss_next    = '0;
                        sel_ok_next = 1'b0;
                        cnt_next    = '0;
                        state_next  = tkst_pkg::ST_FSCAN;
                    end
                end
            end

            default:
            begin
                state_next = tkst_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid      = ovld_reg;
    assign result.out_doc_id = odoc_reg;
    assign result.out_score  = oscore_reg;
    assign result.last       = olast_reg;

endmodule

### design/top_k_score_tracker.sv
// channel  | dir | handshake      | payload
// item     | in  | valid / ready  | doc_id, score, query_end
// result   | out | valid / ready  | out_doc_id, out_score, last
// cfg      | in  | apb write/read | keep_count at byte address 0
//
// an item passes through accept, a pass over the slot memory
// (one read a cycle, registered read data) and a write-back
// a flush makes one memory pass per kept entry (one per rank), one pass if empty
// rst_n clears the slot flags and control; the slot memory itself is not cleared
// a stalled result holds in the output register while the next rank is searched
module top_k_score_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    tkst_item_if.sink                           item,
    tkst_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tkst_pkg::CfgAddrBits-1:0]    paddr,
    input  logic [tkst_pkg::CfgDataBits-1:0]    pwdata,
    output logic [tkst_pkg::CfgDataBits-1:0]    prdata,
    output logic                                pready
);

    tkst_pkg::count_t              eff_k;
    tkst_pkg::store_req_t          req;
    tkst_pkg::store_rd_t           rd;
    logic [tkst_pkg::MaxKept-1:0]  used;

    assign pready = 1'b1;

    tkst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .eff_k   (eff_k)
    );

    tkst_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rd    (rd),
        .used  (used)
    );

    tkst_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .eff_k  (eff_k),
        .item   (item),
        .result (result),
        .req    (req),
        .rd     (rd),
        .used   (used)
    );

endmodule

### sim/top_k_score_tracker_tb.sv
`timescale 1ns / 1ps

module top_k_score_tracker_tb;
    import tkst_pkg::*;

    typedef struct {
        doc_t   doc;
        score_t score;
        logic   last;
    } rank_t;

    localparam int GapMax       = 18;
    localparam int SettleCycles = 40;
    localparam int RandomItems  = 220;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CfgAddrBits-1:0] paddr;
    logic [CfgDataBits-1:0] pwdata;
    logic [CfgDataBits-1:0] prdata;
    logic                   pready;

    tkst_item_if   item ();
    tkst_result_if result ();

    top_k_score_tracker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [KeepBits-1:0] keep_cfg;
    logic                kept_used  [MaxKept];
    doc_t                kept_doc   [MaxKept];
    score_t              kept_score [MaxKept];
    rank_t               ranks_due  [$];
    int                  err_count     = 0;
    int                  items_sent    = 0;
    int                  send_gap_max  = GapMax;
    int                  stall_max     = GapMax;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(16_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        err_count++;
    endtask

    function automatic score_t add_clamped(score_t a, score_t b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return score_t'(s);
    endfunction

    function automatic int keep_limit();
        int k;
        k = int'(keep_cfg);
        if (k < 1)
            k = 1;
        if (k > MaxKept)
            k = MaxKept;
        return k;
    endfunction

    // update the kept set with one transfer and queue the ranking on a flush
    function automatic void track_item(doc_t id, score_t sc, logic flush);
        int     used_n;
        int     free_slot;
        int     min_slot;
        int     best;
        int     n_out;
        logic   hit;
        logic   taken [MaxKept];
        rank_t  r;
        hit = 1'b0;
        used_n = 0;
        free_slot = -1;
        min_slot = -1;
        for (int i = 0; i < MaxKept; i++)
        begin
            if (!hit && kept_used[i] && kept_doc[i] == id)
            begin
                kept_score[i] = add_clamped(kept_score[i], sc);
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            for (int i = 0; i < MaxKept; i++)
            begin
                if (kept_used[i])
                begin
                    used_n++;
                    if (min_slot < 0 || kept_score[i] < kept_score[min_slot])
                        min_slot = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (used_n < keep_limit() && free_slot >= 0)
            begin
                kept_used[free_slot]  = 1'b1;
                kept_doc[free_slot]   = id;
                kept_score[free_slot] = sc;
            end
            else if (min_slot >= 0 && sc > kept_score[min_slot])
            begin
                kept_doc[min_slot]   = id;
                kept_score[min_slot] = sc;
            end
        end
        if (flush)
        begin
            n_out = 0;
            for (int i = 0; i < MaxKept; i++)
                taken[i] = 1'b0;
            do
            begin
                best = -1;
                for (int i = 0; i < MaxKept; i++)
                begin
                    if (kept_used[i] && !taken[i] &&
                        (best < 0 || kept_score[i] > kept_score[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    taken[best] = 1'b1;
                    r.doc   = kept_doc[best];
                    r.score = kept_score[best];
                    r.last  = 1'b0;
                    ranks_due.insert(ranks_due.size(), r);
                    n_out++;
                end
            end
            while (best >= 0);
            if (n_out > 0)
                ranks_due[ranks_due.size()-1].last = 1'b1;
            for (int i = 0; i < MaxKept; i++)
                kept_used[i] = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        rank_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (ranks_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result doc %h score %h",
                                          result.out_doc_id, result.out_score));
            end
            else
            begin
                want = ranks_due.pop_front();
                if (result.out_doc_id !== want.doc)
                    report_mismatch($sformatf("out_doc_id %h, want %h",
                                              result.out_doc_id, want.doc));
                if (result.out_score !== want.score)
                    report_mismatch($sformatf("out_score %h, want %h (doc %h)",
                                              result.out_score, want.score, want.doc));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b (doc %h)",
                                              result.last, want.last, want.doc));
            end
        end
    end

    // result stalls: drawn after each transfer and now and then while idle
    initial
    begin
        int hold;
        hold = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
                hold = $urandom_range(0, stall_max);
            else if (!result.valid && hold == 0 && $urandom_range(0, 3) == 0)
                hold = $urandom_range(0, stall_max);
            if (hold > 0)
            begin
                result.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input doc_t id, input score_t sc, input logic qend);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid     <= 1'b1;
        item.doc_id    <= id;
        item.score     <= sc;
        item.query_end <= qend;
        do @(posedge clk); while (!item.ready);
        track_item(id, sc, qend);
        items_sent++;
    endtask

    task automatic settle();
        item.valid <= 1'b0;
        while (ranks_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_keep(input logic [KeepBits-1:0] kc);
        logic [CfgDataBits-1:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CfgAddrBits'(RegKeepCount * 4);
        pwdata  <= {junk[CfgDataBits-1:KeepBits], kc};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        keep_cfg = kc;
    endtask

    task automatic check_keep_readback();
        logic [CfgDataBits-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CfgAddrBits'(RegKeepCount * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[KeepBits-1:0] !== keep_cfg)
            report_mismatch($sformatf("keep_count read %h, want %h",
                                      got[KeepBits-1:0], keep_cfg));
    endtask

    function automatic logic [KeepBits-1:0] pick_keep();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return KeepBits'(1);
            2:       return KeepBits'(MaxKept);
            3:       return '1;
            default: return KeepBits'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic score_t pick_score();
        case ($urandom_range(0, 5))
            0:       return score_t'($urandom);
            1:       return score_t'($urandom_range(0, 20 * 65536)) - score_t'(10 * 65536);
            2:       return 32'sh7FFFFFFF - score_t'($urandom_range(0, 65536));
            3:       return 32'sh80000000 + score_t'($urandom_range(0, 65536));
            4:       return score_t'($urandom_range(0, 3) * 65536);
            default: return score_t'($urandom_range(0, 100 * 65536));
        endcase
    endfunction

    task automatic test_config_port();
        check_keep_readback();
        write_keep('0);
        check_keep_readback();
        write_keep('1);
        check_keep_readback();
        write_keep(KeepBits'(MaxKept));
        check_keep_readback();
    endtask

    // keep count zero acts as one
    task automatic test_field_extremes();
        write_keep('0);
        send_item(32'h0000_0000, 32'sh8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 32'sh7FFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 32'sh0000_0001, 1'b1);
        settle();
    endtask

    // keep count above the store size, both saturation directions
    task automatic test_saturation();
        write_keep('1);
        send_item(32'h1234_5678, 32'sh7FFF_0000, 1'b0);
        send_item(32'h1234_5678, 32'sh7FFF_0000, 1'b0);
        send_item(32'hA5A5_5A5A, 32'sh8001_0000, 1'b0);
        send_item(32'hA5A5_5A5A, 32'sh8001_0000, 1'b0);
        send_item(32'h0000_FFFF, -32'sh0001_8000, 1'b1);
        settle();
    endtask

    // equal minimums and equal scores in the ranking
    task automatic test_score_ties();
        write_keep(KeepBits'(3));
        send_item(32'd10, 32'sh0001_0000, 1'b0);
        send_item(32'd20, 32'sh0001_0000, 1'b0);
        send_item(32'd30, 32'sh0001_0000, 1'b0);
        send_item(32'd40, 32'sh0001_0000, 1'b0);
        send_item(32'd50, 32'sh0001_8000, 1'b0);
        send_item(32'd30, 32'sh0000_0000, 1'b1);
        settle();
    endtask

    // shrink keep count while six entries are held
    task automatic test_keep_lowered();
        write_keep(KeepBits'(6));
        for (int i = 0; i < 6; i++)
            send_item(doc_t'(100 + i), score_t'((i + 1) * 65536), 1'b0);
        settle();
        write_keep(KeepBits'(2));
        check_keep_readback();
        send_item(32'd200, 32'sh0000_8000, 1'b0);
        send_item(32'd201, 32'sh0004_0000, 1'b0);
        send_item(32'd105, -32'sh0002_0000, 1'b0);
        send_item(32'd202, 32'sh0005_0000, 1'b1);
        settle();
    endtask

    task automatic test_random_queries();
        doc_t   pool [24];
        int     pool_n;
        int     q_len;
        int     first;
        doc_t   id;
        first = items_sent;
        while (items_sent < first + RandomItems)
        begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
            stall_max    = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                write_keep(pick_keep());
                if ($urandom_range(0, 1) == 0)
                    check_keep_readback();
            end
            pool_n = $urandom_range(1, 24);
            for (int i = 0; i < pool_n; i++)
                pool[i] = $urandom;
            q_len = $urandom_range(1, 24);
            for (int j = 0; j < q_len; j++)
            begin
                if ($urandom_range(0, 6) == 0)
                    id = $urandom;
                else
                    id = pool[$urandom_range(0, pool_n - 1)];
                send_item(id, pick_score(), j == q_len - 1);
                if (j < q_len - 1 && $urandom_range(0, 15) == 0)
                begin
                    settle();
                    write_keep(pick_keep());
                end
            end
        end
        send_gap_max = GapMax;
        stall_max    = GapMax;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        item.valid     <= 1'b0;
        item.doc_id    <= '0;
        item.score     <= '0;
        item.query_end <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        keep_cfg        = KeepBits'(KeepReset);
        for (int i = 0; i < MaxKept; i++)
            kept_used[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_port();
        test_field_extremes();
        test_saturation();
        test_score_ties();
        test_keep_lowered();
        test_random_queries();
        settle();

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
design/tkst_pkg.sv
design/tkst_if.sv
design/tkst_cfg.sv
design/tkst_store.sv
design/tkst_engine.sv
design/top_k_score_tracker.sv
sim/top_k_score_tracker_tb.sv
